// File: rtl/fric_pkg.sv
`default_nettype none

package fric_pkg;

    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 120;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int WIDE_IDX_W = 9;

    localparam int SUM_W     = 32;
    localparam int DIVISOR_W = 22;
    localparam int DIV_STEPS = 32;

    localparam logic [MODE_W-1:0] MODE_BYTE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_TICK = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_START_CHAR    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_LIMIT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EIGHTH_PERIOD = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_AVG_SAMPLES   = 2'd3;

    localparam logic [7:0]  RST_START_CHAR    = 8'd35;
    localparam logic [7:0]  RST_IDLE_LIMIT    = 8'd2;
    localparam logic [7:0]  RST_EIGHTH_PERIOD = 8'd32;
    localparam logic [15:0] RST_AVG_SAMPLES   = 16'd480;

    localparam logic [7:0] TIMER_STOPPED = 8'hFF;
    localparam logic [7:0] SECOND_MARK   = 8'hFF;

    localparam logic [DIVISOR_W-1:0] MIN_PER_HOUR = 22'd60;

endpackage

`default_nettype wire

// File: rtl/fric_div.sv
`default_nettype none

module fric_div
    import fric_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic [SUM_W-1:0]     dividend,
    input  wire logic [DIVISOR_W-1:0] divisor,
    output logic                      done,
    output logic [SUM_W-1:0]          quotient
);

    localparam int CNT_W = $clog2(DIV_STEPS);

    logic                 busy_reg;
    logic                 done_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [SUM_W-1:0]     quot_reg;
    logic [DIVISOR_W-1:0] rem_reg;
    logic [DIVISOR_W-1:0] dvs_reg;

    logic [DIVISOR_W:0]   trial;
    logic [DIVISOR_W:0]   diff;
    logic                 fits;

    assign trial = {rem_reg, quot_reg[SUM_W-1]};
    assign fits  = trial >= {1'b0, dvs_reg};
    assign diff  = trial - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // restoring division, one quotient bit per cycle
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quot_reg <= dividend;
            rem_reg  <= '0;
            dvs_reg  <= divisor;
        end
        else if (busy_reg)
        begin
            quot_reg <= {quot_reg[SUM_W-2:0], fits};
            rem_reg  <= fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

`default_nettype wire

// File: rtl/frame_receiver_with_charge_integrator_unit.sv
// Frame receiver with charge integrator.
// Input stream (s_*): one word per item; s_tuser selects received byte, timer
// tick or buffer read. Output stream (m_*): exactly one result word per item,
// carrying pulses, frame length, read byte and the three running totals.
// Config port: cfg_we writes cfg_wdata into the register at cfg_addr; write
// only while no item is in flight.
// Timing: an item passes the execute and load steps, which register its result
// word as valid; a new item is taken only in idle. A tick that closes an
// averaging window first runs two serial divisions, sum / (samples * 60).
// Frame bytes live in a single-port RAM with a registered read; bytes past
// the fill count read as zero, so no clearing pass runs.
// Reset: all counters, sums and totals clear, idle timer stopped, config
// registers to their defaults; the block is ready as soon as reset releases.
// Stall: a held result sits in the output register; the next item is still
// accepted and processed, and its result waits until the held word is taken.
`default_nettype none

module frame_receiver_with_charge_integrator_unit
    import fric_pkg::*;
#(
    parameter int BUF_DEPTH = 64
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // rx_byte[7:0], charge_current[23:8], discharge_current[39:24],
    // read_index[45:40], zero fill [47:46]
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    // mode[1:0]
    input  wire logic [MODE_W-1:0]     s_tuser,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // frame_ready[0], second_pulse[1], eighth_pulse[2], frame_length[8:3],
    // read_data[16:9], charge_total[48:17], discharge_total[80:49],
    // seconds_count[112:81], zero fill [119:113]
    output logic [OUT_DATA_W-1:0]      m_tdata,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int AW = $clog2(BUF_DEPTH);

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_EXEC    = 3'd1;
    localparam logic [2:0] ST_DC_GO   = 3'd2;
    localparam logic [2:0] ST_DC_WAIT = 3'd3;
    localparam logic [2:0] ST_DD_GO   = 3'd4;
    localparam logic [2:0] ST_DD_WAIT = 3'd5;
    localparam logic [2:0] ST_LOAD    = 3'd6;

    logic [2:0] state_reg, state_next;

    logic [7:0]  start_char_reg;
    logic [7:0]  idle_limit_reg;
    logic [7:0]  eighth_period_reg;
    logic [15:0] avg_samples_reg;

    logic [AW-1:0]    byte_count_reg, byte_count_next;
    logic [7:0]       idle_timer_reg, idle_timer_next;
    logic [7:0]       tick_counter_reg, tick_counter_next;
    logic [7:0]       eighth_counter_reg, eighth_counter_next;
    logic [15:0]      sample_counter_reg, sample_counter_next;
    logic [SUM_W-1:0] charge_sum_reg, charge_sum_next;
    logic [SUM_W-1:0] discharge_sum_reg, discharge_sum_next;
    logic [SUM_W-1:0] charge_acc_reg, charge_acc_next;
    logic [SUM_W-1:0] discharge_acc_reg, discharge_acc_next;
    logic [SUM_W-1:0] second_acc_reg, second_acc_next;

    logic                  m_tvalid_reg, m_tvalid_next;
    logic [OUT_DATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic fr_reg, fr_next;
    logic sp_reg, sp_next;
    logic ep_reg, ep_next;
    logic [7:0] rd_reg, rd_next;
    logic [DIVISOR_W-1:0] divisor_reg, divisor_next;

    logic [MODE_W-1:0]     mode_reg;
    logic [7:0]            rx_byte_reg;
    logic [15:0]           chg_reg;
    logic [15:0]           dis_reg;
    logic [WIDE_IDX_W-1:0] idx_wide_reg;

    logic [7:0] mem [BUF_DEPTH];
    logic [7:0] mem_rd_reg;
    logic       mem_we;

    logic                  accept;
    logic [WIDE_IDX_W-1:0] idx_wide;
    logic [AW-1:0]         rd_addr;
    logic [WIDE_IDX_W-1:0] count_wide;
    logic [7:0]            tick_inc;
    logic [7:0]            eighth_inc;
    logic [15:0]           sample_inc;
    logic [15:0]           win_div;
    logic                  out_load;

    logic                 div_start;
    logic                 div_done;
    logic [SUM_W-1:0]     div_q;
    logic [SUM_W-1:0]     div_dividend;

    assign s_tready   = (state_reg == ST_IDLE);
    assign accept     = s_tvalid && s_tready;
    assign idx_wide   = WIDE_IDX_W'(s_tdata[45:40]);
    assign rd_addr    = idx_wide[AW-1:0];
    assign count_wide = WIDE_IDX_W'(byte_count_reg);
    assign tick_inc   = tick_counter_reg + 8'd1;
    assign eighth_inc = eighth_counter_reg + 8'd1;
    assign sample_inc = sample_counter_reg + 16'd1;
    assign win_div    = (sample_inc == 16'd0) ? 16'd1 : sample_inc;

    assign div_dividend = (state_reg == ST_DC_GO) ? charge_sum_reg : discharge_sum_reg;

    fric_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (divisor_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb
    begin
        state_next          = state_reg;
        byte_count_next     = byte_count_reg;
        idle_timer_next     = idle_timer_reg;
        tick_counter_next   = tick_counter_reg;
        eighth_counter_next = eighth_counter_reg;
        sample_counter_next = sample_counter_reg;
        charge_sum_next     = charge_sum_reg;
        discharge_sum_next  = discharge_sum_reg;
        charge_acc_next     = charge_acc_reg;
        discharge_acc_next  = discharge_acc_reg;
        second_acc_next     = second_acc_reg;
        fr_next             = fr_reg;
        sp_next             = sp_reg;
        ep_next             = ep_reg;
        rd_next             = rd_reg;
        divisor_next        = divisor_reg;
        mem_we              = 1'b0;
        div_start           = 1'b0;
        out_load            = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                    state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                fr_next    = 1'b0;
                sp_next    = 1'b0;
                ep_next    = 1'b0;
                rd_next    = 8'd0;
                state_next = ST_LOAD;
                unique case (mode_reg)
                    MODE_BYTE:
                    begin
                        if (rx_byte_reg == start_char_reg)
                        begin
                            byte_count_next = '0;
                            idle_timer_next = 8'd0;
                        end
                        else if (byte_count_reg < AW'(BUF_DEPTH - 1))
                        begin
                            mem_we          = 1'b1;
                            byte_count_next = byte_count_reg + 1'b1;
                        end
                    end
                    MODE_TICK:
                    begin
                        if (idle_timer_reg < idle_limit_reg)
                            idle_timer_next = idle_timer_reg + 8'd1;
                        else if (idle_timer_reg != TIMER_STOPPED)
                        begin
                            fr_next         = 1'b1;
                            idle_timer_next = TIMER_STOPPED;
                        end

                        tick_counter_next = tick_inc;
                        if (tick_inc == SECOND_MARK)
                        begin
                            sp_next         = 1'b1;
                            second_acc_next = second_acc_reg + 32'd1;
                        end

                        if (eighth_inc >= eighth_period_reg)
                        begin
                            eighth_counter_next = 8'd0;
                            ep_next             = 1'b1;
                            if (sample_inc >= avg_samples_reg)
                            begin
                                // window closes: sums folded in by the divider
                                sample_counter_next = 16'd0;
                                divisor_next = {6'd0, win_div} * MIN_PER_HOUR;
                                state_next   = ST_DC_GO;
                            end
                            else
                            begin
                                sample_counter_next = sample_inc;
                                charge_sum_next     = charge_sum_reg + SUM_W'(chg_reg);
                                discharge_sum_next  = discharge_sum_reg + SUM_W'(dis_reg);
                            end
                        end
                        else
                            eighth_counter_next = eighth_inc;
                    end
                    MODE_READ:
                    begin
                        if (idx_wide_reg < WIDE_IDX_W'(BUF_DEPTH) && idx_wide_reg < count_wide)
                            rd_next = mem_rd_reg;
                    end
                    default:
                    begin
                    end
                endcase
            end
            ST_DC_GO:
            begin
                div_start  = 1'b1;
                state_next = ST_DC_WAIT;
            end
            ST_DC_WAIT:
            begin
                if (div_done)
                begin
                    charge_acc_next = charge_acc_reg + div_q;
                    charge_sum_next = '0;
                    state_next      = ST_DD_GO;
                end
            end
            ST_DD_GO:
            begin
                div_start  = 1'b1;
                state_next = ST_DD_WAIT;
            end
            ST_DD_WAIT:
            begin
                if (div_done)
                begin
                    discharge_acc_next = discharge_acc_reg + div_q;
                    discharge_sum_next = '0;
                    state_next         = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (out_load)
        begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {7'd0, second_acc_reg, discharge_acc_reg, charge_acc_reg,
                             rd_reg, count_wide[5:0], ep_reg, sp_reg, fr_reg};
        end
        else if (m_tready)
            m_tvalid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            byte_count_reg     <= '0;
            idle_timer_reg     <= TIMER_STOPPED;
            tick_counter_reg   <= 8'd0;
            eighth_counter_reg <= 8'd0;
            sample_counter_reg <= 16'd0;
            charge_sum_reg     <= '0;
            discharge_sum_reg  <= '0;
            charge_acc_reg     <= '0;
            discharge_acc_reg  <= '0;
            second_acc_reg     <= '0;
            m_tvalid_reg       <= 1'b0;
        end
        else
        begin
            state_reg          <= state_next;
            byte_count_reg     <= byte_count_next;
            idle_timer_reg     <= idle_timer_next;
            tick_counter_reg   <= tick_counter_next;
            eighth_counter_reg <= eighth_counter_next;
            sample_counter_reg <= sample_counter_next;
            charge_sum_reg     <= charge_sum_next;
            discharge_sum_reg  <= discharge_sum_next;
            charge_acc_reg     <= charge_acc_next;
            discharge_acc_reg  <= discharge_acc_next;
            second_acc_reg     <= second_acc_next;
            m_tvalid_reg       <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_char_reg    <= RST_START_CHAR;
            idle_limit_reg    <= RST_IDLE_LIMIT;
            eighth_period_reg <= RST_EIGHTH_PERIOD;
            avg_samples_reg   <= RST_AVG_SAMPLES;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_START_CHAR:    start_char_reg    <= cfg_wdata[7:0];
                CFG_IDLE_LIMIT:    idle_limit_reg    <= cfg_wdata[7:0];
                CFG_EIGHTH_PERIOD: eighth_period_reg <= cfg_wdata[7:0];
                CFG_AVG_SAMPLES:   avg_samples_reg   <= cfg_wdata;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        fr_reg      <= fr_next;
        sp_reg      <= sp_next;
        ep_reg      <= ep_next;
        rd_reg      <= rd_next;
        divisor_reg <= divisor_next;
        m_tdata_reg <= m_tdata_next;
        if (accept)
        begin
            mode_reg     <= s_tuser;
            rx_byte_reg  <= s_tdata[7:0];
            chg_reg      <= s_tdata[23:8];
            dis_reg      <= s_tdata[39:24];
            idx_wide_reg <= idx_wide;
        end
    end

    // frame RAM; the execute step returns zero for bytes at or above the fill count
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[byte_count_reg] <= rx_byte_reg;
        if (accept)
            mem_rd_reg <= mem[rd_addr];
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTH
    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DC_WAIT || state_reg == ST_DD_WAIT))
        else $error("divider finished outside a wait state");

    a_load_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg == ST_LOAD))
        else $error("result word raised outside the load step");

    a_window_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DC_GO) |-> (sample_counter_reg == 16'd0))
        else $error("sample count not cleared on window close");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_wide <= WIDE_IDX_W'(BUF_DEPTH - 1))
        else $error("frame byte count past buffer limit");
`endif

endmodule

`default_nettype wire

// File: tb/sv/tb_frame_receiver_with_charge_integrator_unit.sv
module tb_frame_receiver_with_charge_integrator_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import fric_pkg::*;

    localparam int BUF_DEPTH = 64;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

    typedef struct packed {
        logic [1:0]  fill;
        logic [5:0]  read_index;
        logic [15:0] discharge_current;
        logic [15:0] charge_current;
        logic [7:0]  rx_byte;
    } rx_item_t;

    typedef struct packed {
        logic [6:0]  fill;
        logic [31:0] seconds_count;
        logic [31:0] discharge_total;
        logic [31:0] charge_total;
        logic [7:0]  read_data;
        logic [5:0]  frame_length;
        logic        eighth_pulse;
        logic        second_pulse;
        logic        frame_ready;
    } status_word_t;

    class frame_charge_scoreboard;
        logic [7:0]   start_chr;
        logic [7:0]   idle_lim;
        logic [7:0]   eighth_per;
        logic [15:0]  avg_win;
        logic [7:0]   frame_copy [BUF_DEPTH];
        int unsigned  byte_cnt;
        logic [7:0]   idle_tmr;
        logic [7:0]   tick_cnt;
        logic [7:0]   eighth_cnt;
        logic [15:0]  samples;
        logic [31:0]  chg_sum;
        logic [31:0]  dis_sum;
        logic [31:0]  chg_total;
        logic [31:0]  dis_total;
        logic [31:0]  sec_total;
        status_word_t pending_words [$];
        int           errors;

        function new();
            start_chr  = RST_START_CHAR;
            idle_lim   = RST_IDLE_LIMIT;
            eighth_per = RST_EIGHTH_PERIOD;
            avg_win    = RST_AVG_SAMPLES;
            foreach (frame_copy[i])
                frame_copy[i] = 8'h00;
            byte_cnt   = 0;
            idle_tmr   = TIMER_STOPPED;
            tick_cnt   = 8'h00;
            eighth_cnt = 8'h00;
            samples    = 16'h0000;
            chg_sum    = 32'h0;
            dis_sum    = 32'h0;
            chg_total  = 32'h0;
            dis_total  = 32'h0;
            sec_total  = 32'h0;
            errors     = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_START_CHAR:    start_chr  = val[7:0];
                CFG_IDLE_LIMIT:    idle_lim   = val[7:0];
                CFG_EIGHTH_PERIOD: eighth_per = val[7:0];
                CFG_AVG_SAMPLES:   avg_win    = val;
                default: ;
            endcase
        endfunction

        function int pending();
            return pending_words.size();
        endfunction

        function void note_item(logic [MODE_W-1:0] mode, rx_item_t it);
            status_word_t r;
            logic [31:0]  divisor;
            r = '0;
            case (mode)
                MODE_BYTE:
                begin
                    if (it.rx_byte == start_chr)
                    begin
                        idle_tmr = 8'h00;
                        foreach (frame_copy[i])
                            frame_copy[i] = 8'h00;
                        byte_cnt = 0;
                    end
                    else if (byte_cnt < BUF_DEPTH - 1)
                    begin
                        frame_copy[byte_cnt] = it.rx_byte;
                        byte_cnt++;
                    end
                end
                MODE_TICK:
                begin
                    if (idle_tmr < idle_lim)
                        idle_tmr = idle_tmr + 8'd1;
                    else if (idle_tmr < TIMER_STOPPED)
                    begin
                        r.frame_ready = 1'b1;
                        idle_tmr = TIMER_STOPPED;
                    end
                    tick_cnt = tick_cnt + 8'd1;
                    if (tick_cnt == SECOND_MARK)
                    begin
                        r.second_pulse = 1'b1;
                        sec_total = sec_total + 32'd1;
                    end
                    eighth_cnt = eighth_cnt + 8'd1;
                    if (eighth_cnt >= eighth_per)
                    begin
                        eighth_cnt = 8'h00;
                        r.eighth_pulse = 1'b1;
                        samples = samples + 16'd1;
                        if (samples >= avg_win)
                        begin
                            divisor = (samples == 16'd0) ? 32'd1 : {16'd0, samples};
                            chg_total = chg_total + (chg_sum / divisor) / MIN_PER_HOUR;
                            dis_total = dis_total + (dis_sum / divisor) / MIN_PER_HOUR;
                            chg_sum = 32'h0;
                            dis_sum = 32'h0;
                            samples = 16'h0000;
                        end
                        else
                        begin
                            chg_sum = chg_sum + it.charge_current;
                            dis_sum = dis_sum + it.discharge_current;
                        end
                    end
                end
                MODE_READ:
                    r.read_data = frame_copy[it.read_index];
                default: ;
            endcase
            r.frame_length    = 6'(byte_cnt);
            r.charge_total    = chg_total;
            r.discharge_total = dis_total;
            r.seconds_count   = sec_total;
            pending_words.push_back(r);
        endfunction

        function void flag(string what, logic [31:0] want, logic [31:0] got);
            errors++;
            if (errors <= 10)
                $display("mismatch %s: expected %0h, got %0h", what, want, got);
        endfunction

        function void check_word(status_word_t got);
            status_word_t want;
            if (pending_words.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result word %h", got);
                return;
            end
            want = pending_words.pop_front();
            if (got.frame_ready !== want.frame_ready)
                flag("frame_ready", want.frame_ready, got.frame_ready);
            if (got.second_pulse !== want.second_pulse)
                flag("second_pulse", want.second_pulse, got.second_pulse);
            if (got.eighth_pulse !== want.eighth_pulse)
                flag("eighth_pulse", want.eighth_pulse, got.eighth_pulse);
            if (got.frame_length !== want.frame_length)
                flag("frame_length", want.frame_length, got.frame_length);
            if (got.read_data !== want.read_data)
                flag("read_data", want.read_data, got.read_data);
            if (got.charge_total !== want.charge_total)
                flag("charge_total", want.charge_total, got.charge_total);
            if (got.discharge_total !== want.discharge_total)
                flag("discharge_total", want.discharge_total, got.discharge_total);
            if (got.seconds_count !== want.seconds_count)
                flag("seconds_count", want.seconds_count, got.seconds_count);
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic [MODE_W-1:0]     s_tuser = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    frame_charge_scoreboard board = new();
    bit no_idle = 1'b0;
    int items_sent = 0;
    int cycle_count = 0;

    frame_receiver_with_charge_integrator_unit #(
        .BUF_DEPTH(BUF_DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .m_tdata(m_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .cfg_we(cfg_we),
        .cfg_addr(cfg_addr),
        .cfg_wdata(cfg_wdata)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("frame_receiver_with_charge_integrator_unit test failed");
            $finish;
        end
    end

    function automatic logic [15:0] pick_current();
        case ($urandom_range(3))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_word(input logic [MODE_W-1:0] mode, input logic [7:0] rx,
                             input logic [15:0] chg, input logic [15:0] dis,
                             input logic [5:0] idx);
        rx_item_t it;
        int gap;
        it.fill = 2'b00;
        it.read_index = idx;
        it.discharge_current = dis;
        it.charge_current = chg;
        it.rx_byte = rx;
        gap = no_idle ? 0 : $urandom_range(9);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= it;
        s_tuser  <= mode;
        do @(posedge clk); while (!s_tready);
        board.note_item(mode, it);
        items_sent++;
    endtask

    task automatic send_tick();
        send_word(MODE_TICK, 8'($urandom), pick_current(), pick_current(), 6'($urandom));
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_word(MODE_BYTE, b, 16'($urandom), 16'($urandom), 6'($urandom));
    endtask

    task automatic send_read(input logic [5:0] idx);
        send_word(MODE_READ, 8'($urandom), 16'($urandom), 16'($urandom), idx);
    endtask

    // registers change only with nothing in flight
    task automatic apply_setup(input logic [7:0] sc, input logic [7:0] il,
                               input logic [7:0] ep, input logic [15:0] av);
        s_tvalid <= 1'b0;
        while (board.pending() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= CFG_START_CHAR;
        cfg_wdata <= {8'h00, sc};
        @(posedge clk);
        cfg_addr  <= CFG_IDLE_LIMIT;
        cfg_wdata <= {8'h00, il};
        @(posedge clk);
        cfg_addr  <= CFG_EIGHTH_PERIOD;
        cfg_wdata <= {8'h00, ep};
        @(posedge clk);
        cfg_addr  <= CFG_AVG_SAMPLES;
        cfg_wdata <= av;
        @(posedge clk);
        cfg_we    <= 1'b0;
        board.set_reg(CFG_START_CHAR, {8'h00, sc});
        board.set_reg(CFG_IDLE_LIMIT, {8'h00, il});
        board.set_reg(CFG_EIGHTH_PERIOD, {8'h00, ep});
        board.set_reg(CFG_AVG_SAMPLES, av);
    endtask

    initial
    begin : sink
        int stall;
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(9);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            board.check_word(status_word_t'(m_tdata));
        end
    end

    initial
    begin : stimulus
        logic [7:0]  ph_start  [6];
        logic [7:0]  ph_idle   [6];
        logic [7:0]  ph_eighth [6];
        logic [15:0] ph_avg    [6];
        int phase_end;
        int pick;
        int n;
        int top;

        ph_start[0] = 8'h00;         ph_idle[0] = 8'd1;   ph_eighth[0] = 8'd1;   ph_avg[0] = 16'd1;
        ph_start[1] = 8'hFF;         ph_idle[1] = 8'd254; ph_eighth[1] = 8'd255; ph_avg[1] = 16'hFFFF;
        ph_start[2] = 8'($urandom);  ph_idle[2] = 8'($urandom_range(1, 6));
        ph_eighth[2] = 8'($urandom_range(1, 3));  ph_avg[2] = 16'($urandom_range(2, 12));
        ph_start[3] = 8'($urandom);  ph_idle[3] = 8'd0;   ph_eighth[3] = 8'd0;   ph_avg[3] = 16'd0;
        ph_start[4] = 8'($urandom);  ph_idle[4] = 8'd255; ph_eighth[4] = 8'd2;   ph_avg[4] = 16'd3;
        ph_start[5] = 8'($urandom);  ph_idle[5] = 8'($urandom_range(1, 6));
        ph_eighth[5] = 8'($urandom_range(1, 4));  ph_avg[5] = 16'($urandom_range(2, 12));

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: empty store, unused mode, bytes, restart, idle expiry
        send_read(6'd0);
        send_word(MODE_SPARE, 8'hFF, 16'hFFFF, 16'hFFFF, 6'd63);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_read(6'd1);
        send_byte(RST_START_CHAR);
        send_byte(8'hA5);
        send_read(6'd0);
        send_read(6'd63);
        send_word(MODE_TICK, 8'h00, 16'h0000, 16'h0000, 6'd0);
        send_word(MODE_TICK, 8'hFF, 16'hFFFF, 16'hFFFF, 6'd63);
        send_tick();
        send_tick();

        // zero limit, zero period, zero window
        apply_setup(8'h00, 8'd0, 8'd0, 16'd0);
        send_byte(8'h00);
        send_tick();
        send_tick();
        send_byte(8'h23);
        send_read(6'd0);

        for (int ph = 0; ph < 6; ph++)
        begin
            apply_setup(ph_start[ph], ph_idle[ph], ph_eighth[ph], ph_avg[ph]);
            phase_end = items_sent + 200;
            while (items_sent < phase_end)
            begin
                no_idle = ($urandom_range(4) == 0);
                pick = $urandom_range(99);
                if (pick < 30)
                begin
                    // well-formed frame: start, payload, a few reads back
                    send_byte(board.start_chr);
                    n = ($urandom_range(7) == 0) ? $urandom_range(55, 70) : $urandom_range(10);
                    repeat (n) send_byte(8'($urandom));
                    top = (n + 1 > 63) ? 63 : n + 1;
                    repeat ($urandom_range(3)) send_read(6'($urandom_range(top)));
                end
                else if (pick < 55)
                begin
                    n = ($urandom_range(4) == 0) ? int'(board.idle_lim) + 2
                                                 : $urandom_range(1, 8);
                    repeat (n) send_tick();
                end
                else if (pick < 70)
                begin
                    repeat ($urandom_range(1, 6))
                    begin
                        top = (board.byte_cnt + 1 > 63) ? 63 : board.byte_cnt + 1;
                        if ($urandom_range(1) == 0)
                            send_read(6'($urandom_range(top)));
                        else
                            send_read(6'($urandom));
                    end
                end
                else if (pick < 85)
                begin
                    repeat ($urandom_range(1, 8))
                        send_byte(($urandom_range(7) == 0) ? board.start_chr : 8'($urandom));
                end
                else
                begin
                    repeat ($urandom_range(1, 4))
                        send_word(2'($urandom), 8'($urandom), pick_current(), pick_current(),
                                  6'($urandom));
                end
            end
        end

        no_idle = 1'b0;
        s_tvalid <= 1'b0;
        while (board.pending() != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        if (board.errors == 0 && board.pending() == 0)
            $display("frame_receiver_with_charge_integrator_unit test passed");
        else
            $display("frame_receiver_with_charge_integrator_unit test failed");
        $finish;
    end

endmodule

// File: frame_receiver_with_charge_integrator_unit.f
rtl/fric_pkg.sv
rtl/fric_div.sv
rtl/frame_receiver_with_charge_integrator_unit.sv
tb/sv/tb_frame_receiver_with_charge_integrator_unit.sv
